// File: rtl/assert_macros.svh
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clock and reset given explicitly.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Uses the usual i_clk / i_rst_n pair of the enclosing module.
`define ASSERT_SYNC(label, prop, msg) \
    `ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// File: rtl/bqf_pkg.sv
package bqf_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int STATE_BITS  = 32;

    localparam int FRAC_SHIFT  = COEF_BITS - 2;
    // Horner accumulator: coefficient times the widest serial operand
    localparam int MAC_W       = COEF_BITS + STATE_BITS;
    // Three-term sums before rounding
    localparam int SUM_W       = MAC_W + 2;
    localparam int SHR_W       = SUM_W - FRAC_SHIFT;
    localparam int CNT_W       =
        $clog2((SAMPLE_BITS > STATE_BITS) ? SAMPLE_BITS : STATE_BITS);

    localparam int NUM_COEF    = 5;
    localparam int CFG_IDX_W   = $clog2(NUM_COEF);

    localparam logic [CFG_IDX_W-1:0] CFG_B0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_B1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_B2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_A1 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_A2 = CFG_IDX_W'(4);

    localparam logic signed [COEF_BITS-1:0] COEF_ONE   = COEF_BITS'(1) << (COEF_BITS - 2);
    localparam logic signed [SUM_W-1:0]     ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [STATE_BITS-1:0]  t_state_word;
    typedef logic signed [MAC_W-1:0]       t_mac;
    typedef logic signed [SUM_W-1:0]       t_sum;

    typedef struct packed {
        t_coef b0;
        t_coef b1;
        t_coef b2;
        t_coef a1;
        t_coef a2;
    } t_coefs;

    typedef struct packed {
        logic clear;
        logic step;
        logic msb;
    } t_mac_ctl;

    typedef struct packed {
        t_sample sample;
        logic    clip;
    } t_result;

    typedef struct packed {
        t_state_word val;
        logic        clip;
    } t_rs;

    typedef struct packed {
        t_sample val;
        logic    clip;
    } t_sat_smp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULX,
        ST_FORMY,
        ST_MULY,
        ST_UPDATE,
        ST_DONE
    } t_seq_state;

    // Round half up to the state scale, then clamp to STATE_BITS.
    function automatic t_rs round_sat(input t_sum a);
        t_sum             t;
        logic [SHR_W-1:0] s;
        t_rs              r;
        t = a + ROUND_HALF;
        s = t[SUM_W-1:FRAC_SHIFT];
        if ((&s[SHR_W-1:STATE_BITS-1]) || !(|s[SHR_W-1:STATE_BITS-1])) begin
            r.val  = s[STATE_BITS-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = s[SHR_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                : {1'b0, {(STATE_BITS-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sat_smp sat_sample(input t_state_word y);
        t_sat_smp r;
        if ((&y[STATE_BITS-1:SAMPLE_BITS-1]) || !(|y[STATE_BITS-1:SAMPLE_BITS-1])) begin
            r.val  = y[SAMPLE_BITS-1:0];
            r.clip = 1'b0;
        end else begin
            r.val  = y[STATE_BITS-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic t_sum ext_mac(input t_mac v);
        return {{(SUM_W-MAC_W){v[MAC_W-1]}}, v};
    endfunction

    // State word moved to product scale
    function automatic t_sum ext_state(input t_state_word v);
        return {{(SUM_W-STATE_BITS-FRAC_SHIFT){v[STATE_BITS-1]}}, v, {FRAC_SHIFT{1'b0}}};
    endfunction

endpackage

// File: rtl/bqf_if.sv
interface bqf_in_if import bqf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    logic    restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

interface bqf_out_if import bqf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

// File: rtl/biquad_iir_filter.sv
// Biquad IIR, transposed direct form II, bit-serial multipliers.
// Per sample: the 24 x bits pass through the b multipliers, y is formed, the
// 32 y bits pass through the a multipliers, the state is updated, and the
// result goes to the output register. No new sample is taken before that.
// Reset (sync, active low): both filter states zero, b0 = 1.0, other coefs 0.
module biquad_iir_filter import bqf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_BITS-1:0] i_cfg_data,
    bqf_in_if.sink               i_smp,
    bqf_out_if.source            o_smp
);

    t_coefs  r_coefs;
    logic    seq_idle;
    logic    res_valid;
    t_result res;
    logic    res_take;

    logic    r_out_valid;
    t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_ONE;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_B0:  r_coefs.b0 <= i_cfg_data;
                CFG_B1:  r_coefs.b1 <= i_cfg_data;
                CFG_B2:  r_coefs.b2 <= i_cfg_data;
                CFG_A1:  r_coefs.a1 <= i_cfg_data;
                CFG_A2:  r_coefs.a2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign i_smp.ready = seq_idle;

    bqf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_smp.valid),
        .i_sample   (i_smp.sample_in),
        .i_restart  (i_smp.restart),
        .i_coefs    (r_coefs),
        .o_idle     (seq_idle),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_take (res_take)
    );

    // output register: result moves in when empty or being drained
    assign res_take = res_valid && (!r_out_valid || o_smp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (o_smp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_smp.valid      = r_out_valid;
    assign o_smp.sample_out = r_out.sample;
    assign o_smp.clipped    = r_out.clip;

endmodule

// File: rtl/bqf_mac.sv
// Bit-serial multiply, multiplier MSB first (Horner): acc = 2*acc +/- coef*bit.
// The first bit carries negative weight.
module bqf_mac import bqf_pkg::*; (
    input  logic     i_clk,
    input  t_mac_ctl i_ctl,
    input  logic     i_bit,
    input  t_coef    i_coef,
    output t_mac     o_acc
);

    t_mac r_acc;
    t_mac n_acc;
    t_mac coef_ext;
    t_mac term;

    always_comb begin
        coef_ext = {{(MAC_W-COEF_BITS){i_coef[COEF_BITS-1]}}, i_coef};
        if (!i_bit) begin
            term = '0;
        end else if (i_ctl.msb) begin
            term = -coef_ext;
        end else begin
            term = coef_ext;
        end
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_ctl.step) begin
            n_acc = {r_acc[MAC_W-2:0], 1'b0} + term;
        end else begin
            n_acc = r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/bqf_seq.sv
module bqf_seq import bqf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_sample i_sample,
    input  logic    i_restart,
    input  t_coefs  i_coefs,
    output logic    o_idle,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_take
);

    t_seq_state r_state;
    t_seq_state n_state;

    logic [CNT_W-1:0]       r_cnt;
    logic [SAMPLE_BITS-1:0] r_xsh;
    logic [STATE_BITS-1:0]  r_ysh;
    t_state_word            r_ft;
    t_state_word            r_st;
    t_sample                r_yo;
    logic                   r_clip;

    t_mac_ctl ctl_x;
    t_mac_ctl ctl_y;
    logic     last_x;
    logic     last_y;

    t_mac acc_b0;
    t_mac acc_b1;
    t_mac acc_b2;
    t_mac acc_a1;
    t_mac acc_a2;

    t_rs      y_rs;
    t_sat_smp y_smp;
    t_rs      n0_rs;
    t_rs      n1_rs;

    assign last_x = (r_cnt == CNT_W'(SAMPLE_BITS - 1));
    assign last_y = (r_cnt == CNT_W'(STATE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        ctl_x       = '0;
        ctl_y       = '0;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_idle      = 1'b1;
                ctl_x.clear = 1'b1;
                ctl_y.clear = 1'b1;
                if (i_start) begin
                    n_state = ST_MULX;
                end
            end
            ST_MULX: begin
                ctl_x.step = 1'b1;
                ctl_x.msb  = (r_cnt == '0);
                if (last_x) begin
                    n_state = ST_FORMY;
                end
            end
            ST_FORMY: begin
                n_state = ST_MULY;
            end
            ST_MULY: begin
                ctl_y.step = 1'b1;
                ctl_y.msb  = (r_cnt == '0);
                if (last_y) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    bqf_mac u_mac_b0 (.i_clk(i_clk), .i_ctl(ctl_x), .i_bit(r_xsh[SAMPLE_BITS-1]),
                      .i_coef(i_coefs.b0), .o_acc(acc_b0));
    bqf_mac u_mac_b1 (.i_clk(i_clk), .i_ctl(ctl_x), .i_bit(r_xsh[SAMPLE_BITS-1]),
                      .i_coef(i_coefs.b1), .o_acc(acc_b1));
    bqf_mac u_mac_b2 (.i_clk(i_clk), .i_ctl(ctl_x), .i_bit(r_xsh[SAMPLE_BITS-1]),
                      .i_coef(i_coefs.b2), .o_acc(acc_b2));
    bqf_mac u_mac_a1 (.i_clk(i_clk), .i_ctl(ctl_y), .i_bit(r_ysh[STATE_BITS-1]),
                      .i_coef(i_coefs.a1), .o_acc(acc_a1));
    bqf_mac u_mac_a2 (.i_clk(i_clk), .i_ctl(ctl_y), .i_bit(r_ysh[STATE_BITS-1]),
                      .i_coef(i_coefs.a2), .o_acc(acc_a2));

    always_comb begin
        y_rs  = round_sat(ext_state(r_ft) + ext_mac(acc_b0));
        y_smp = sat_sample(y_rs.val);
        // a1*y and a2*y are subtracted
        n0_rs = round_sat(ext_state(r_st) + ext_mac(acc_b1) - ext_mac(acc_a1));
        n1_rs = round_sat(ext_mac(acc_b2) - ext_mac(acc_a2));
    end

    // filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ft <= '0;
            r_st <= '0;
        end else if (r_state == ST_IDLE && i_start && i_restart) begin
            r_ft <= '0;
            r_st <= '0;
        end else if (r_state == ST_UPDATE) begin
            r_ft <= n0_rs.val;
            r_st <= n1_rs.val;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_xsh <= i_sample;
                r_cnt <= '0;
            end
            ST_MULX: begin
                r_xsh <= {r_xsh[SAMPLE_BITS-2:0], 1'b0};
                r_cnt <= last_x ? '0 : r_cnt + 1'b1;
            end
            ST_FORMY: begin
                r_ysh  <= y_rs.val;
                r_yo   <= y_smp.val;
                r_clip <= y_rs.clip | y_smp.clip;
            end
            ST_MULY: begin
                r_ysh <= {r_ysh[STATE_BITS-2:0], 1'b0};
                r_cnt <= last_y ? '0 : r_cnt + 1'b1;
            end
            ST_UPDATE: begin
                r_clip <= r_clip | n0_rs.clip | n1_rs.clip;
            end
            default: begin
            end
        endcase
    end

    assign o_res.sample = r_yo;
    assign o_res.clip   = r_clip;

endmodule

// File: rtl/bqf_checker.sv
`include "assert_macros.svh"

module bqf_checker import bqf_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_sample,
    input logic    i_out_clipped
);

    // a sample is worked on alone: busy right after its transfer
    `ASSERT_SYNC(a_busy_after_in, i_in_valid && i_in_ready |=> !i_in_ready, "input taken while busy")

    // no result can show up the cycle after a sample is taken
    `ASSERT_SYNC(a_no_instant_out, i_in_valid && i_in_ready && !i_out_valid |=> !i_out_valid, "result too early")

    // a new result is handed off as the sequencer returns to idle
    `ASSERT_CLK(a_idle_on_result, i_clk, i_rst_n, $rose(i_out_valid) |-> i_in_ready, "result without idle")

    `ASSERT_SYNC(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample) && $stable(i_out_clipped), "stalled result changed")

endmodule

bind biquad_iir_filter bqf_checker u_bqf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_smp.valid),
    .i_out_ready  (o_smp.ready),
    .i_out_sample (o_smp.sample_out),
    .i_out_clipped(o_smp.clipped)
);
